// ----- rtl/kmtp_pkg.sv -----
// kmtp_pkg: shared constants, types and helpers for the k-mer two-bit packer
// no dependencies; imported by every module of the block

package kmtp_pkg;

   localparam int MaxBases   = 32;
   localparam int CodeWidth  = 2;
   localparam int WinWidth   = CodeWidth * MaxBases;
   localparam int KmerWidth  = 64;
   localparam int KWidth     = 6;
   localparam int CharWidth  = 8;
   localparam int DataWidth  = 32;
   localparam int AddrWidth  = 5;
   localparam int RegIdxWidth = 3;

   localparam logic [KWidth-1:0] KReset = KWidth'(21);
   localparam logic [KWidth-1:0] KMax   = KWidth'(MaxBases);

   localparam logic [CharWidth-1:0] CharUpperA = 8'h41;
   localparam logic [CharWidth-1:0] CharLowerA = 8'h61;
   localparam logic [CharWidth-1:0] CharUpperC = 8'h43;
   localparam logic [CharWidth-1:0] CharLowerC = 8'h63;
   localparam logic [CharWidth-1:0] CharUpperG = 8'h47;
   localparam logic [CharWidth-1:0] CharLowerG = 8'h67;
   localparam logic [CharWidth-1:0] CharUpperT = 8'h54;
   localparam logic [CharWidth-1:0] CharLowerT = 8'h74;

   typedef enum logic [RegIdxWidth-1:0] {
      REG_KMER_SIZE  = 3'd0,
      REG_CODE_FOR_A = 3'd1,
      REG_CODE_FOR_C = 3'd2,
      REG_CODE_FOR_G = 3'd3,
      REG_CODE_FOR_T = 3'd4
   } reg_idx_type;

   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_SHIFT = 2'd1,
      CELL_LOAD  = 2'd2,
      CELL_ZERO  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        clear;
   } cell_ctrl_type;

   function automatic logic [KWidth-1:0] effective_k(input logic [KWidth-1:0] k);
      logic [KWidth-1:0] r;
      r = k;
      if (k == '0) begin
         r = KWidth'(1);
      end else if (k > KMax) begin
         r = KMax;
      end
      return r;
   endfunction

endpackage

// ----- rtl/kmtp_cell.sv -----
// kmtp_cell: one two-bit slot of the sliding base window
// depends on kmtp_pkg; instantiated in a row by the top level

module kmtp_cell
   import kmtp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic [CodeWidth-1:0] neighbor,
   input  logic [CodeWidth-1:0] code,
   output logic [CodeWidth-1:0] slot_next,
   output logic [CodeWidth-1:0] slot
);

   logic [CodeWidth-1:0] slot_ff;
   logic [CodeWidth-1:0] slot_in;

   always_comb begin
      case (ctrl.op)
         CELL_HOLD:  slot_next = slot_ff;
         CELL_SHIFT: slot_next = neighbor;
         CELL_LOAD:  slot_next = code;
         CELL_ZERO:  slot_next = '0;
         default:    slot_next = slot_ff;
      endcase
      slot_in = ctrl.clear ? '0 : slot_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule

// ----- rtl/kmtp_out_buf.sv -----
// kmtp_out_buf: output register with a skid stage for packed k-mers
// depends on kmtp_pkg

module kmtp_out_buf
   import kmtp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [KmerWidth-1:0] push_data,
   output logic                 space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [KmerWidth-1:0] out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [KmerWidth-1:0] main_data_ff, main_data_in;
   logic [KmerWidth-1:0] skid_data_ff, skid_data_in;
   logic                 pop;

   always_comb begin
      pop           = main_valid_ff && out_ready;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_data_in  = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

// ----- rtl/kmer_two_bit_packer_core.sv -----
// kmer_two_bit_packer_core: top level of the k-mer two-bit packer
// depends on kmtp_pkg, kmtp_cell and kmtp_out_buf
//
// usage: characters enter on the req_ channel (req_base_char, req_record_end)
// and packed k-mers leave on the rsp_ channel (rsp_kmer_code), both with
// valid/ready. A, C, G, T in either case shift their two-bit code into a row
// of 32 two-bit cells; the newest base lands at slot k-1 and the oldest sits
// in bits 1:0. Each valid base ending a run of k or more valid bases yields
// one item. Other characters clear the window; a record end clears it after
// its own base has been used. k and the four codes are set through the csr_
// APB port; the user must change them only while the block is idle; the block
// does not check this. throughput: one item per cycle while the skid stage
// has space. a k-mer goes to the output register, or to the skid stage if
// that is full and not read, when its last base is taken. a stalled receiver
// fills the output register and then the skid stage; req_ready falls only
// while the skid stage is full. reset clears the window, the run count, the
// output stages and restores k = 21 and codes A=0, C=1, G=2, T=3.

module kmer_two_bit_packer_core
   import kmtp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CharWidth-1:0] req_base_char,
   input  logic                 req_record_end,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [KmerWidth-1:0] rsp_kmer_code,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [DataWidth-1:0] csr_pwdata,
   output logic [DataWidth-1:0] csr_prdata,
   output logic                 csr_pready
);

   logic [KWidth-1:0]    kmer_size_ff, kmer_size_in;
   logic [CodeWidth-1:0] code_a_ff, code_a_in;
   logic [CodeWidth-1:0] code_c_ff, code_c_in;
   logic [CodeWidth-1:0] code_g_ff, code_g_in;
   logic [CodeWidth-1:0] code_t_ff, code_t_in;
   logic [KWidth-1:0]    run_ff, run_in;

   logic                 csr_write;
   reg_idx_type          reg_idx;
   logic                 accept;
   logic                 base_ok;
   logic [CodeWidth-1:0] base_code;
   logic [KWidth-1:0]    k_eff;
   logic [KWidth:0]      run_inc;
   logic                 emit;
   logic [WinWidth-1:0]  win_next;
   logic [WinWidth-1:0]  win;
   logic                 buf_space;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = reg_idx_type'(csr_paddr[AddrWidth-1:2]);

   always_comb begin
      kmer_size_in = kmer_size_ff;
      code_a_in    = code_a_ff;
      code_c_in    = code_c_ff;
      code_g_in    = code_g_ff;
      code_t_in    = code_t_ff;
      csr_prdata   = '0;
      case (reg_idx)
         REG_KMER_SIZE: begin
            csr_prdata = DataWidth'(kmer_size_ff);
            if (csr_write) kmer_size_in = csr_pwdata[KWidth-1:0];
         end
         REG_CODE_FOR_A: begin
            csr_prdata = DataWidth'(code_a_ff);
            if (csr_write) code_a_in = csr_pwdata[CodeWidth-1:0];
         end
         REG_CODE_FOR_C: begin
            csr_prdata = DataWidth'(code_c_ff);
            if (csr_write) code_c_in = csr_pwdata[CodeWidth-1:0];
         end
         REG_CODE_FOR_G: begin
            csr_prdata = DataWidth'(code_g_ff);
            if (csr_write) code_g_in = csr_pwdata[CodeWidth-1:0];
         end
         REG_CODE_FOR_T: begin
            csr_prdata = DataWidth'(code_t_ff);
            if (csr_write) code_t_in = csr_pwdata[CodeWidth-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   // base decode
   always_comb begin
      base_ok   = 1'b1;
      base_code = '0;
      case (req_base_char)
         CharUpperA, CharLowerA: base_code = code_a_ff;
         CharUpperC, CharLowerC: base_code = code_c_ff;
         CharUpperG, CharLowerG: base_code = code_g_ff;
         CharUpperT, CharLowerT: base_code = code_t_ff;
         default:                base_ok   = 1'b0;
      endcase
   end

   assign k_eff     = effective_k(kmer_size_ff);
   assign req_ready = buf_space;
   assign accept    = req_valid && req_ready;

   // run counter
   always_comb begin
      run_inc = {1'b0, run_ff} + (KWidth+1)'(1);
      emit    = accept && base_ok && (run_inc >= {1'b0, k_eff});
      run_in  = run_ff;
      if (accept) begin
         if (!base_ok || req_record_end) begin
            run_in = '0;
         end else if (run_inc < {1'b0, k_eff}) begin
            run_in = run_inc[KWidth-1:0];
         end else begin
            run_in = k_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_size_ff <= KReset;
         code_a_ff    <= CodeWidth'(0);
         code_c_ff    <= CodeWidth'(1);
         code_g_ff    <= CodeWidth'(2);
         code_t_ff    <= CodeWidth'(3);
         run_ff       <= '0;
      end else begin
         kmer_size_ff <= kmer_size_in;
         code_a_ff    <= code_a_in;
         code_c_ff    <= code_c_in;
         code_g_ff    <= code_g_in;
         code_t_ff    <= code_t_in;
         run_ff       <= run_in;
      end
   end

   // row of window cells
   for (genvar j = 0; j < MaxBases; j++) begin : g_cell
      cell_ctrl_type        ctrl;
      logic [CodeWidth-1:0] neighbor;

      if (j == MaxBases - 1) begin : g_end
         assign neighbor = '0;
      end else begin : g_mid
         assign neighbor = win[CodeWidth*(j+1) +: CodeWidth];
      end

      always_comb begin
         ctrl.clear = accept && req_record_end;
         if (!accept) begin
            ctrl.op = CELL_HOLD;
         end else if (!base_ok) begin
            ctrl.op = CELL_ZERO;
         end else if (KWidth'(j + 1) == k_eff) begin
            ctrl.op = CELL_LOAD;
         end else if (KWidth'(j + 1) < k_eff) begin
            ctrl.op = CELL_SHIFT;
         end else begin
            ctrl.op = CELL_ZERO;
         end
      end

      kmtp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .neighbor  (neighbor),
         .code      (base_code),
         .slot_next (win_next[CodeWidth*j +: CodeWidth]),
         .slot      (win[CodeWidth*j +: CodeWidth])
      );
   end

   kmtp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (KmerWidth'(win_next)),
      .space     (buf_space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_kmer_code)
   );

endmodule

// ----- tb/kmer_two_bit_packer_checker.sv -----
// kmer_two_bit_packer_checker: watches the item, result and register ports of the packer,
// keeps its own window and run count, predicts each k-mer and compares it with rsp_
// depends on kmtp_pkg; hands a failure count and the number of k-mers in flight to the top

module kmer_two_bit_packer_checker
   import kmtp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [CharWidth-1:0] req_base_char,
   input  logic                 req_record_end,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [KmerWidth-1:0] rsp_kmer_code,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic                 csr_pready,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [DataWidth-1:0] csr_pwdata,
   output int                   fail_count,
   output int                   pending_count
);

   logic [KWidth-1:0]    k_setting;
   logic [CodeWidth-1:0] code_a;
   logic [CodeWidth-1:0] code_c;
   logic [CodeWidth-1:0] code_g;
   logic [CodeWidth-1:0] code_t;
   logic [KmerWidth-1:0] window;
   int                   run_len;
   logic [KmerWidth-1:0] kmer_due_q[$];
   logic [KmerWidth-1:0] due_kmer;
   int                   errors = 0;

   task automatic advance_window(input logic [CharWidth-1:0] ch, input logic rec_last);
      int                   k;
      logic [KmerWidth-1:0] keep;
      logic [CodeWidth-1:0] code;
      logic                 is_base;
      k = (k_setting == 0) ? 1 : ((k_setting > MaxBases) ? MaxBases : int'(k_setting));
      keep = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
      is_base = 1'b1;
      code = '0;
      case (ch)
         CharUpperA, CharLowerA: code = code_a;
         CharUpperC, CharLowerC: code = code_c;
         CharUpperG, CharLowerG: code = code_g;
         CharUpperT, CharLowerT: code = code_t;
         default: is_base = 1'b0;
      endcase
      if (is_base) begin
         window = (((window & keep) >> 2) | (KmerWidth'(code) << (2 * (k - 1)))) & keep;
         run_len = (run_len + 1 < k) ? run_len + 1 : k;
         if (run_len >= k) begin
            kmer_due_q.push_back(window);
         end
      end else begin
         window = '0;
         run_len = 0;
      end
      if (rec_last) begin
         window = '0;
         run_len = 0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         k_setting = KReset;
         code_a = 2'd0;
         code_c = 2'd1;
         code_g = 2'd2;
         code_t = 2'd3;
         window = '0;
         run_len = 0;
         kmer_due_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (kmer_due_q.size() == 0) begin
               $display("%0t: kmer_code expected none actual %h", $time, rsp_kmer_code);
               errors = errors + 1;
            end else begin
               due_kmer = kmer_due_q.pop_front();
               if (rsp_kmer_code !== due_kmer) begin
                  $display("%0t: kmer_code expected %h actual %h", $time, due_kmer,
                           rsp_kmer_code);
                  errors = errors + 1;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[AddrWidth-1:2])
               REG_KMER_SIZE:  k_setting = csr_pwdata[KWidth-1:0];
               REG_CODE_FOR_A: code_a = csr_pwdata[CodeWidth-1:0];
               REG_CODE_FOR_C: code_c = csr_pwdata[CodeWidth-1:0];
               REG_CODE_FOR_G: code_g = csr_pwdata[CodeWidth-1:0];
               REG_CODE_FOR_T: code_t = csr_pwdata[CodeWidth-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_window(req_base_char, req_record_end);
         end
      end
      fail_count <= errors;
      pending_count <= kmer_due_q.size();
   end

endmodule

// ----- tb/kmer_two_bit_packer_core_tb.sv -----
// kmer_two_bit_packer_core_tb: drives characters, register writes and receiver stalls
// into kmer_two_bit_packer_core; verdict from the checker's failure and pending counts
// depends on kmtp_pkg, kmer_two_bit_packer_core and kmer_two_bit_packer_checker

module kmer_two_bit_packer_core_tb;
   import kmtp_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int LongHold   = 60;
   localparam logic [RegIdxWidth-1:0] SpareRegIdx = 3'd6;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CharWidth-1:0] req_base_char = '0;
   logic                 req_record_end = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [KmerWidth-1:0] rsp_kmer_code;
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [AddrWidth-1:0] csr_paddr = '0;
   logic [DataWidth-1:0] csr_pwdata = '0;
   logic [DataWidth-1:0] csr_prdata;
   logic                 csr_pready;

   int fail_count;
   int pending_count;
   int cycles = 0;
   int burst_left = 0;
   int steady_left = 0;
   int hold_requests = 0;
   int holds_taken;
   int hold_left;
   int seg_left;
   int ready_pct;

   kmer_two_bit_packer_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_base_char  (req_base_char),
      .req_record_end (req_record_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kmer_code  (rsp_kmer_code),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   kmer_two_bit_packer_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_base_char  (req_base_char),
      .req_record_end (req_record_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kmer_code  (rsp_kmer_code),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("kmer_two_bit_packer_core verification failed");
         $finish;
      end
   end

   // receiver: segments of differing readiness, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         seg_left = 0;
         holds_taken = 0;
         ready_pct = 100;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_taken != hold_requests) begin
         holds_taken = holds_taken + 1;
         hold_left = LongHold - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(8, 60);
            ready_pct = 100 - 25 * $urandom_range(0, 3);
         end
         seg_left = seg_left - 1;
         rsp_ready <= ($urandom_range(0, 99) < ready_pct);
      end
   end

   function automatic logic [CharWidth-1:0] pick_char(input int noise_pct);
      logic [CharWidth-1:0] ch;
      if ($urandom_range(0, 99) < noise_pct) begin
         ch = CharWidth'($urandom_range(0, 255));
      end else begin
         case ($urandom_range(0, 3))
            0: ch = CharUpperA;
            1: ch = CharUpperC;
            2: ch = CharUpperG;
            default: ch = CharUpperT;
         endcase
         // lower case
         if ($urandom_range(0, 1) == 1) begin
            ch = ch | 8'h20;
         end
      end
      return ch;
   endfunction

   task automatic offer_base(input logic [CharWidth-1:0] ch, input logic rec_last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (steady_left == 0 && $urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left = burst_left - 1;
      if (steady_left > 0) begin
         steady_left = steady_left - 1;
      end
      req_valid <= 1'b1;
      req_base_char <= ch;
      req_record_end <= rec_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic offer_text(input string s, input bit end_record);
      for (int i = 0; i < s.len(); i++) begin
         offer_base(s[i], end_record && (i == s.len() - 1));
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      repeat (3) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [RegIdxWidth-1:0] idx, input logic [DataWidth-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [KWidth-1:0] k, input logic [CodeWidth-1:0] a,
                            input logic [CodeWidth-1:0] c, input logic [CodeWidth-1:0] g,
                            input logic [CodeWidth-1:0] t);
      csr_write(REG_KMER_SIZE, {(DataWidth-KWidth)'($urandom), k});
      csr_write(REG_CODE_FOR_A, {(DataWidth-CodeWidth)'($urandom), a});
      csr_write(REG_CODE_FOR_C, {(DataWidth-CodeWidth)'($urandom), c});
      csr_write(REG_CODE_FOR_G, {(DataWidth-CodeWidth)'($urandom), g});
      csr_write(REG_CODE_FOR_T, {(DataWidth-CodeWidth)'($urandom), t});
   endtask

   task automatic run_phase(input int n_items, input int max_rec, input int noise_pct,
                            input bit squeeze);
      int rec_left;
      rec_left = $urandom_range(1, max_rec);
      for (int i = 0; i < n_items; i++) begin
         if (squeeze && i == n_items / 4) begin
            hold_requests <= hold_requests + 1;
            steady_left = LongHold + 20;
         end
         offer_base(pick_char(noise_pct), rec_left == 1);
         rec_left = (rec_left == 1) ? $urandom_range(1, max_rec) : rec_left - 1;
      end
      wait_idle();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_phase(120, 50, 3, 1'b0);

      configure(6'd4, 2'd0, 2'd1, 2'd2, 2'd3);
      offer_text("ACGTac", 1'b1);
      offer_text("gt", 1'b0);
      offer_base(8'h00, 1'b0);
      offer_text("ACG", 1'b0);
      offer_base(8'hFF, 1'b0);
      // record too short for a k-mer
      offer_text("tgc", 1'b1);
      offer_text("aTGC", 1'b0);
      offer_base(8'h80, 1'b1);
      wait_idle();

      configure(6'd1, 2'd3, 2'd2, 2'd1, 2'd0);
      run_phase(110, 8, 10, 1'b0);
      configure(6'd32, 2'd0, 2'd1, 2'd2, 2'd3);
      run_phase(130, 90, 1, 1'b1);
      // equal codes, k of zero
      configure(6'd0, 2'd1, 2'd1, 2'd1, 2'd1);
      run_phase(100, 6, 10, 1'b0);
      configure(6'd63, 2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
      run_phase(110, 90, 1, 1'b0);
      csr_write(SpareRegIdx, $urandom);
      configure(6'd2, 2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
      run_phase(100, 10, 8, 1'b0);
      configure(6'd33, 2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
      run_phase(100, 80, 1, 1'b0);
      configure(6'd5, 2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
      run_phase(100, 14, 6, 1'b1);
      configure(6'd16, 2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
      run_phase(120, 40, 3, 1'b0);
      configure(6'd3, 2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
      run_phase(100, 9, 8, 1'b0);
      configure(6'd21, 2'd0, 2'd1, 2'd2, 2'd3);
      run_phase(110, 50, 2, 1'b0);

      if (fail_count == 0 && pending_count == 0) begin
         $display("kmer_two_bit_packer_core verification clean");
      end else begin
         $display("kmer_two_bit_packer_core verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/kmtp_pkg.sv
rtl/kmtp_cell.sv
rtl/kmtp_out_buf.sv
rtl/kmer_two_bit_packer_core.sv
tb/kmer_two_bit_packer_checker.sv
tb/kmer_two_bit_packer_core_tb.sv
